// ===== hw/rtl/rlc_pkg.sv =====
// Shared types, constants and helper functions for the RGB layer compositor.
// Used by the channel interfaces and every compositor module but rlc_ram; depends on nothing.

package rlc_pkg;

  // Frame store and pixel geometry.
  localparam int PIXEL_W = 8;
  localparam int PIXELS  = 2 ** PIXEL_W;
  localparam int CHAN_W  = 8;
  localparam int CHANS   = 3;
  localparam int RGB_W   = CHANS * CHAN_W;

  // Layer configuration layout.
  localparam int LAYERS  = 4;
  localparam int LAYER_W = 2;
  localparam int MODE_W  = 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_OPACITIES = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODES     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENABLES   = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALPHA = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_MAX   = 2'd2,
    MODE_MULT  = 2'd3
  } mode_t;

  // Channel order: index 2 red, 1 green, 0 blue (matches the stored word).
  typedef logic [CHANS-1:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic [LAYERS*CHAN_W-1:0] opacities;
    logic [LAYERS*MODE_W-1:0] modes;
    logic [LAYERS-1:0]        enables;
  } cfg_t;

  // One classified layer pixel waiting for the back end.
  typedef struct packed {
    logic [PIXEL_W-1:0] index;
    logic               first;
    logic               enabled;
    mode_t              mode;
    logic [CHAN_W-1:0]  opacity;
    rgb_t               src;
  } job_t;

  // Exact x / 255 for x up to 255 * 255, with adds only.
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
    logic [2*CHAN_W:0] t;
    t = (2*CHAN_W+1)'(x) + (2*CHAN_W+1)'(x[2*CHAN_W-1:CHAN_W]) + 1'b1;
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ===== hw/rtl/rlc_in_if.sv =====
// Input channel of the compositor: one layer pixel per transaction.
// Depends on rlc_pkg for field widths.

interface rlc_in_if;
  logic                               valid;
  logic                               ready;
  logic [rlc_pkg::PIXEL_W-1:0]        pixel_index;
  logic [rlc_pkg::LAYER_W-1:0]        layer_index;
  logic                               first_layer;
  logic [rlc_pkg::CHAN_W-1:0]         layer_red;
  logic [rlc_pkg::CHAN_W-1:0]         layer_green;
  logic [rlc_pkg::CHAN_W-1:0]         layer_blue;

  modport source (
    output valid, pixel_index, layer_index, first_layer, layer_red, layer_green, layer_blue,
    input  ready
  );
  modport sink (
    input  valid, pixel_index, layer_index, first_layer, layer_red, layer_green, layer_blue,
    output ready
  );
endinterface

// ===== hw/rtl/rlc_out_if.sv =====
// Output channel of the compositor: one composited pixel per transaction.
// Depends on rlc_pkg for field widths.

interface rlc_out_if;
  logic                               valid;
  logic                               ready;
  logic [rlc_pkg::PIXEL_W-1:0]        result_index;
  logic [rlc_pkg::CHAN_W-1:0]         out_red;
  logic [rlc_pkg::CHAN_W-1:0]         out_green;
  logic [rlc_pkg::CHAN_W-1:0]         out_blue;
  logic                               layer_applied;

  modport source (
    output valid, result_index, out_red, out_green, out_blue, layer_applied,
    input  ready
  );
  modport sink (
    input  valid, result_index, out_red, out_green, out_blue, layer_applied,
    output ready
  );
endinterface

// ===== hw/rtl/rlc_ram.sv =====
// Generic single-write, single-read RAM with a registered, read-first output.
// Standalone; used for the frame store.

module rlc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rlc_regs.sv =====
// APB-style configuration registers: layer opacities, modes and enables.
// Depends on rlc_pkg for the register map and the configuration struct.

module rlc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rlc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rlc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rlc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output rlc_pkg::cfg_t                cfg
);

  logic                              wr_en;
  logic [rlc_pkg::REG_IDX_W-1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[rlc_pkg::PADDR_W-1:2];

  // Register writes in the access phase; register index 3 is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.opacities <= '1;
      cfg.modes     <= '0;
      cfg.enables   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rlc_pkg::REG_OPACITIES: cfg.opacities <= pwdata[rlc_pkg::LAYERS*rlc_pkg::CHAN_W-1:0];
        rlc_pkg::REG_MODES:     cfg.modes     <= pwdata[rlc_pkg::LAYERS*rlc_pkg::MODE_W-1:0];
        rlc_pkg::REG_ENABLES:   cfg.enables   <= pwdata[rlc_pkg::LAYERS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      rlc_pkg::REG_OPACITIES: prdata = rlc_pkg::PDATA_W'(cfg.opacities);
      rlc_pkg::REG_MODES:     prdata = rlc_pkg::PDATA_W'(cfg.modes);
      rlc_pkg::REG_ENABLES:   prdata = rlc_pkg::PDATA_W'(cfg.enables);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/rlc_front.sv =====
// Front end: accepts layer pixels and classifies them against the layer
// configuration into queue entries. Depends on rlc_pkg and rlc_in_if.

module rlc_front (
  rlc_in_if.sink            pixels,
  input  rlc_pkg::cfg_t     cfg,
  input  logic              queue_full,
  output logic              push,
  output rlc_pkg::job_t     push_job
);

  logic [rlc_pkg::LAYER_W-1:0] layer;

  assign layer        = pixels.layer_index;
  assign pixels.ready = !queue_full;
  assign push         = pixels.valid && !queue_full;

  // Look up the layer's enable, opacity and mode.
  always_comb begin
    push_job.index   = pixels.pixel_index;
    push_job.first   = pixels.first_layer;
    push_job.enabled = (32'(layer) < rlc_pkg::LAYERS) && cfg.enables[layer];
    push_job.opacity = cfg.opacities[layer*rlc_pkg::CHAN_W +: rlc_pkg::CHAN_W];
    push_job.mode    = rlc_pkg::mode_t'(cfg.modes[layer*rlc_pkg::MODE_W +: rlc_pkg::MODE_W]);
    push_job.src     = {pixels.layer_red, pixels.layer_green, pixels.layer_blue};
  end

endmodule

// ===== hw/rtl/rlc_queue.sv =====
// Short FIFO of classified jobs between the front and the back end.
// Depends on rlc_pkg for the job type and depth.

module rlc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlc_pkg::job_t     push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output rlc_pkg::job_t     head_job
);

  rlc_pkg::job_t                 entries [rlc_pkg::QUEUE_DEPTH];
  logic [rlc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rlc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rlc_pkg::QPTR_W:0]      count;

  assign full       = (count == (rlc_pkg::QPTR_W+1)'(rlc_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/rlc_back.sv =====
// Back end: frame-store read, blend pipeline, write-back and output register.
// Depends on rlc_pkg, rlc_out_if and rlc_ram.

module rlc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rlc_pkg::job_t     head_job,
  output logic              pop,
  rlc_out_if.source         results
);

  localparam int PW = 2 * rlc_pkg::CHAN_W;

  // Stage handshake.
  logic out_valid, out_free;
  logic s1_valid, s1_free, s1_adv;
  logic s2_valid, s2_free, s2_adv;

  // Frame store and its fill marks.
  logic [rlc_pkg::PIXELS-1:0]  filled;
  logic [rlc_pkg::RGB_W-1:0]   rd_data;

  // Most recent write, for the read-during-write case.
  logic                        lw_valid;
  logic [rlc_pkg::PIXEL_W-1:0] lw_index;
  rlc_pkg::rgb_t               lw_data;

  // Stage 1: source products and stored pixel.
  rlc_pkg::job_t               s1_job;
  logic                        s1_filled;
  logic [2:0][PW-1:0]          s1_sop;
  logic [2:0][PW-1:0]          s1_sop1;
  logic [2:0][PW-1:0]          head_sop;
  logic [2:0][PW-1:0]          head_sop1;
  rlc_pkg::rgb_t               s1_scaled;
  rlc_pkg::rgb_t               s1_dst;

  // Stage 2: blend.
  logic [rlc_pkg::PIXEL_W-1:0] s2_index;
  logic                        s2_enabled;
  rlc_pkg::mode_t              s2_mode;
  logic [rlc_pkg::CHAN_W-1:0]  s2_op;
  rlc_pkg::rgb_t               s2_dst;
  rlc_pkg::rgb_t               s2_scaled;
  logic [2:0][PW-1:0]          s2_sop1;
  logic [2:0][rlc_pkg::CHAN_W:0] mul_b;
  logic [2:0][PW:0]            prod;
  logic [2:0][PW:0]            alpha_sum;
  logic [2:0][rlc_pkg::CHAN_W:0] add_sum;
  rlc_pkg::rgb_t               mixed;
  rlc_pkg::rgb_t               s2_res;

  // Output register.
  logic [rlc_pkg::PIXEL_W-1:0] out_index;
  rlc_pkg::rgb_t               out_rgb;
  logic                        out_applied;

  // A stage moves when the one after it is free or moving.
  assign out_free = !out_valid || results.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s2_adv   = s2_valid && out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_adv   = s1_valid && s2_free;
  assign pop      = head_valid && s1_free;

  rlc_ram #(
    .WIDTH (rlc_pkg::RGB_W),
    .DEPTH (rlc_pkg::PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (s2_adv),
    .waddr (s2_index),
    .wdata (s2_res),
    .re    (pop),
    .raddr (head_job.index),
    .rdata (rd_data)
  );

  // Source products, taken from the queue head as it enters stage 1.
  always_comb begin
    for (int c = 0; c < rlc_pkg::CHANS; c++) begin
      head_sop[c]  = PW'(head_job.src[c]) * PW'(head_job.opacity);
      head_sop1[c] = PW'(head_job.src[c]) * (PW'(head_job.opacity) + 1'b1);
    end
  end

  // Scaled source and forwarded destination. The pixel in stage 2 writes at
  // the same edge this one moves on, so its result wins over older data.
  always_comb begin
    for (int c = 0; c < rlc_pkg::CHANS; c++) begin
      s1_scaled[c] = rlc_pkg::div255(s1_sop[c]);
    end
    if (s1_job.first) begin
      s1_dst = '0;
    end else if (s2_valid && (s2_index == s1_job.index)) begin
      s1_dst = s2_res;
    end else if (lw_valid && (lw_index == s1_job.index)) begin
      s1_dst = lw_data;
    end else if (s1_filled) begin
      s1_dst = rd_data;
    end else begin
      s1_dst = '0;
    end
  end

  // Blend per channel; one shared multiply serves alpha and multiply modes.
  always_comb begin
    for (int c = 0; c < rlc_pkg::CHANS; c++) begin
      if (s2_mode == rlc_pkg::MODE_ALPHA) begin
        mul_b[c] = 9'd256 - {1'b0, s2_op};
      end else begin
        mul_b[c] = {1'b0, s2_scaled[c]};
      end
      prod[c]      = (PW+1)'(s2_dst[c]) * (PW+1)'(mul_b[c]);
      alpha_sum[c] = prod[c] + (PW+1)'(s2_sop1[c]);
      add_sum[c]   = {1'b0, s2_dst[c]} + {1'b0, s2_scaled[c]};
      case (s2_mode)
        rlc_pkg::MODE_ALPHA: mixed[c] = alpha_sum[c][PW-1:rlc_pkg::CHAN_W];
        rlc_pkg::MODE_ADD:   mixed[c] = add_sum[c][rlc_pkg::CHAN_W] ? rlc_pkg::CHAN_MAX
                                                                    : add_sum[c][rlc_pkg::CHAN_W-1:0];
        rlc_pkg::MODE_MAX:   mixed[c] = (s2_dst[c] > s2_scaled[c]) ? s2_dst[c] : s2_scaled[c];
        rlc_pkg::MODE_MULT:  mixed[c] = rlc_pkg::div255(prod[c][PW-1:0]);
        default:             mixed[c] = s2_dst[c];
      endcase
    end
    s2_res = s2_enabled ? mixed : s2_dst;
  end

  // Pipeline control, fill marks and last-write record.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      lw_valid  <= 1'b0;
      filled    <= '0;
    end else begin
      if (s1_free) begin
        s1_valid <= head_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
      if (s2_adv) begin
        lw_valid         <= 1'b1;
        filled[s2_index] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_job    <= head_job;
      s1_sop    <= head_sop;
      s1_sop1   <= head_sop1;
      s1_filled <= filled[head_job.index];
    end
    if (s1_adv) begin
      s2_index   <= s1_job.index;
      s2_enabled <= s1_job.enabled;
      s2_mode    <= s1_job.mode;
      s2_op      <= s1_job.opacity;
      s2_dst     <= s1_dst;
      s2_scaled  <= s1_scaled;
      s2_sop1    <= s1_sop1;
    end
    if (s2_adv) begin
      lw_index    <= s2_index;
      lw_data     <= s2_res;
      out_index   <= s2_index;
      out_rgb     <= s2_res;
      out_applied <= s2_enabled;
    end
  end

  assign results.valid         = out_valid;
  assign results.result_index  = out_index;
  assign results.out_red       = out_rgb[2];
  assign results.out_green     = out_rgb[1];
  assign results.out_blue      = out_rgb[0];
  assign results.layer_applied = out_applied;

endmodule

// ===== hw/rtl/rgb_layer_compositor_unit.sv =====
// Top level of the RGB layer compositor: configuration registers, front end,
// job queue and blend back end. Depends on rlc_pkg, the channel interfaces and
// rlc_regs, rlc_front, rlc_queue, rlc_back.
//
// Usage: layer pixels arrive on the pixels channel (valid/ready). Each one is
// blended by its layer's mode and opacity into a 256-entry RGB frame store,
// and the stored pixel comes back on the results channel, one transaction out
// for every transaction in, in the same order.
// Configuration is written over the APB-style port (opacities at 0x0, modes at
// 0x4, enables at 0x8) only while no pixel is in flight: the user is bound to
// this, the block does not enforce it; pready is always high. An accepted pixel
// goes through the queue, store read and blend before results. Throughput: one
// pixel per cycle while results does not stall, including back-to-back pixels
// to the same frame-store entry, forwarded around the store's single write and
// single registered read port. When results stalls, the output register holds;
// the four-entry queue keeps accepting until it fills, then pixels.ready drops.
// Reset clears the configuration to full opacity, alpha mode, all layers
// disabled, and marks every frame-store entry black at once.

module rgb_layer_compositor_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rlc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rlc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rlc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  rlc_in_if.sink                       pixels,
  rlc_out_if.source                    results
);

  rlc_pkg::cfg_t cfg;
  rlc_pkg::job_t push_job;
  rlc_pkg::job_t head_job;
  logic          push;
  logic          queue_full;
  logic          head_valid;
  logic          pop;

  rlc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlc_front u_front (
    .pixels     (pixels),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  rlc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  rlc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .results    (results)
  );

endmodule

// ===== hw/rtl/rlc_checker.sv =====
// Port-level checks for the RGB layer compositor and the bind that attaches
// them to rgb_layer_compositor_unit. Depends on rlc_pkg for field widths.

module rlc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rlc_pkg::PIXEL_W-1:0] out_index,
  input logic [rlc_pkg::CHAN_W-1:0]  out_red,
  input logic [rlc_pkg::CHAN_W-1:0]  out_green,
  input logic [rlc_pkg::CHAN_W-1:0]  out_blue,
  input logic                        out_applied
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Pixels taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // A result is never shown without a pixel behind it.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (pending != 4'd0))
    else $error("result presented with no pixel in flight");

  // Queue plus pipeline hold at most seven pixels.
  assert property (@(posedge clk) disable iff (rst) pending <= 4'd7)
    else $error("more pixels in flight than the block can hold");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({out_index, out_red, out_green, out_blue, out_applied}))
    else $error("result payload changed while stalled");

endmodule

bind rgb_layer_compositor_unit rlc_checker u_rlc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixels.valid),
  .in_ready    (pixels.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_index   (results.result_index),
  .out_red     (results.out_red),
  .out_green   (results.out_green),
  .out_blue    (results.out_blue),
  .out_applied (results.layer_applied)
);
